@@ rtl/core/ptms_pkg.sv @@
// ptms_pkg: shared constants, codes and types of the point tolerance match search.
// Used by ptms_table, ptms_dist_unit, point_tolerance_match_search and ptms_checker.
package ptms_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;

	// Field widths
	localparam int COORD_W   = 32;
	localparam int TOL_W     = 31;
	localparam int LIM_W     = 12;
	localparam int IDX_OUT_W = 11;

	// Arithmetic widths: magnitudes of 2^31 or more are never near
	localparam int MAG_W  = 31;
	localparam int PROD_W = 2 * MAG_W;
	localparam int ACC_W  = PROD_W + 2;

	// Opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOL,
		ST_FEED,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	// Axis fed to the distance unit
	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	// One table row
	typedef struct packed {
		logic               sel;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} entry_t;

	// Tag that travels with each operand pair through the distance unit
	typedef struct packed {
		logic              is_tol;
		logic              first;
		logic              last;
		logic              sel;
		logic [ADDR_W-1:0] idx;
	} dist_tag_t;

	// Distance unit result and status
	typedef struct packed {
		logic              busy;
		logic              valid;
		logic              ovf;
		logic [PROD_W-1:0] prod;
		dist_tag_t         tag;
	} dist_res_t;

endpackage

@@ rtl/core/ptms_table.sv @@
// ptms_table: point table memory, one write port and one registered read port.
// Depends on ptms_pkg for the depth and the row type.
module ptms_table (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ptms_pkg::ADDR_W-1:0]  wr_addr,
	input  ptms_pkg::entry_t             wr_data,
	input  logic                         rd_en,
	input  logic [ptms_pkg::ADDR_W-1:0]  rd_addr,
	output ptms_pkg::entry_t             rd_data
);

	ptms_pkg::entry_t mem_q [ptms_pkg::TABLE_DEPTH];
	ptms_pkg::entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/ptms_dist_unit.sv @@
// ptms_dist_unit: shared two-stage unit, |a - b| then its square, one axis per cycle.
// Depends on ptms_pkg for widths and the tag and result types.
module ptms_dist_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          flush,
	input  logic                          in_valid,
	input  logic [ptms_pkg::COORD_W-1:0]  op_a,
	input  logic [ptms_pkg::COORD_W-1:0]  op_b,
	input  ptms_pkg::dist_tag_t           tag_in,
	output ptms_pkg::dist_res_t           res
);

	logic signed [ptms_pkg::COORD_W:0] a_ext;
	logic signed [ptms_pkg::COORD_W:0] b_ext;
	logic signed [ptms_pkg::COORD_W:0] d_ab;
	logic signed [ptms_pkg::COORD_W:0] d_ba;
	logic        [ptms_pkg::COORD_W:0] mag;
	logic                              ovf;
	logic        [ptms_pkg::PROD_W-1:0] sq;

	logic                             valid_s1;
	logic                             ovf_s1;
	logic [ptms_pkg::MAG_W-1:0]       mag_s1;
	ptms_pkg::dist_tag_t              tag_s1;
	logic                             valid_s2;
	logic                             ovf_s2;
	logic [ptms_pkg::PROD_W-1:0]      prod_s2;
	ptms_pkg::dist_tag_t              tag_s2;

	// Stage 1: both differences side by side, keep the non-negative one
	always_comb begin
		a_ext = {op_a[ptms_pkg::COORD_W-1], op_a};
		b_ext = {op_b[ptms_pkg::COORD_W-1], op_b};
		d_ab  = a_ext - b_ext;
		d_ba  = b_ext - a_ext;
		mag   = d_ab[ptms_pkg::COORD_W] ? d_ba : d_ab;
		ovf   = |mag[ptms_pkg::COORD_W:ptms_pkg::MAG_W];
	end

	// Stage 2: square of the magnitude
	assign sq = mag_s1 * mag_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (flush) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		mag_s1  <= mag[ptms_pkg::MAG_W-1:0];
		ovf_s1  <= ovf;
		tag_s1  <= tag_in;
		prod_s2 <= sq;
		ovf_s2  <= ovf_s1;
		tag_s2  <= tag_s1;
	end

	always_comb begin
		res.busy  = valid_s1 | valid_s2;
		res.valid = valid_s2;
		res.ovf   = ovf_s2;
		res.prod  = prod_s2;
		res.tag   = tag_s2;
	end

endmodule

@@ rtl/core/point_tolerance_match_search.sv @@
// point_tolerance_match_search: 3-D point table with a linear exact / tolerance search.
// Depends on ptms_pkg, ptms_table and ptms_dist_unit.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | to block  | in_valid / in_ready  | opcode entry_index coord_x/y/z is_selected
//          |           |                      | scan_limit
//  out     | from block| out_valid / out_ready| found match_index (one per query)
//  cfg     | to block  | cfg_valid / cfg_ready| match_tolerance
//
// A query scans the entries in turn: the shared distance unit handles one axis per cycle,
// so each entry passes through it as its x, y and z axes in that order.
// An exact match ends the scan early. One item is worked on at a time.
// After reset a clearing pass writes all 1024 table rows, one per cycle; in_ready
// stays low until the pass ends. cfg_ready is always high.
// A finished result waits in the output register; writes keep flowing meanwhile.
module point_tolerance_match_search (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic [ptms_pkg::ADDR_W-1:0]        entry_index,
	input  logic signed [ptms_pkg::COORD_W-1:0] coord_x,
	input  logic signed [ptms_pkg::COORD_W-1:0] coord_y,
	input  logic signed [ptms_pkg::COORD_W-1:0] coord_z,
	input  logic                               is_selected,
	input  logic signed [ptms_pkg::LIM_W-1:0]  scan_limit,
	// output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic signed [ptms_pkg::IDX_OUT_W-1:0] match_index,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptms_pkg::TOL_W-1:0]         match_tolerance
);

	ptms_pkg::seq_state_t state_q, state_d;

	logic [ptms_pkg::ADDR_W-1:0]  clr_idx_q;
	logic [ptms_pkg::CNT_W-1:0]   count_q;
	logic [ptms_pkg::TOL_W-1:0]   tol_q;
	logic [ptms_pkg::COORD_W-1:0] qx_q, qy_q, qz_q;
	logic [ptms_pkg::CNT_W-1:0]   stop_q;
	logic [ptms_pkg::CNT_W-1:0]   feed_idx_q;
	ptms_pkg::axis_t              axis_q;
	logic [ptms_pkg::ACC_W-1:0]   acc_q;
	logic                         ovf_acc_q;
	logic [ptms_pkg::PROD_W-1:0]  tol2_q;
	logic                         hit_q;
	logic [ptms_pkg::ADDR_W-1:0]  hit_idx_q;
	logic                         out_valid_q;
	logic                         found_q;
	logic [ptms_pkg::IDX_OUT_W-1:0] match_index_q;

	logic                         in_fire;
	logic                         wr_fire;
	logic                         qry_fire;
	logic                         tbl_wr_en;
	logic [ptms_pkg::ADDR_W-1:0]  tbl_wr_addr;
	ptms_pkg::entry_t             tbl_wr_data;
	logic                         tbl_rd_en;
	logic [ptms_pkg::ADDR_W-1:0]  tbl_rd_addr;
	ptms_pkg::entry_t             tbl_rd_data;
	logic [ptms_pkg::CNT_W-1:0]   next_idx;
	logic [ptms_pkg::CNT_W-1:0]   widx_p1;
	logic [ptms_pkg::LIM_W-2:0]   lim_mag;
	logic [ptms_pkg::LIM_W-2:0]   count_ext;
	logic [ptms_pkg::CNT_W-1:0]   stop_d;

	logic                         du_valid;
	logic [ptms_pkg::COORD_W-1:0] du_a, du_b;
	ptms_pkg::dist_tag_t          du_tag;
	ptms_pkg::dist_res_t          du_res;

	logic                         proc;
	logic [ptms_pkg::ACC_W-1:0]   sum;
	logic                         ovf_any;
	logic                         cand;
	logic                         exact;
	logic                         near;
	logic                         out_load;

	// Handshakes
	assign in_ready  = (state_q == ptms_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid & in_ready;
	assign wr_fire   = in_fire & (opcode == ptms_pkg::OP_WRITE);
	assign qry_fire  = in_fire & (opcode == ptms_pkg::OP_QUERY);
	assign out_load  = (state_q == ptms_pkg::ST_FINISH) & (~out_valid_q | out_ready);

	// Table write: clearing pass or a write transaction
	always_comb begin
		tbl_wr_en   = (state_q == ptms_pkg::ST_CLEAR) | wr_fire;
		tbl_wr_addr = (state_q == ptms_pkg::ST_CLEAR) ? clr_idx_q : entry_index;
		if (state_q == ptms_pkg::ST_CLEAR) begin
			tbl_wr_data = '0;
		end else begin
			tbl_wr_data.sel = is_selected;
			tbl_wr_data.x   = coord_x;
			tbl_wr_data.y   = coord_y;
			tbl_wr_data.z   = coord_z;
		end
	end

	// Scan bound: smaller of a non-negative limit and the entry count
	always_comb begin
		lim_mag   = scan_limit[ptms_pkg::LIM_W-2:0];
		count_ext = (ptms_pkg::LIM_W-1)'(count_q);
		if (!scan_limit[ptms_pkg::LIM_W-1] && (lim_mag < count_ext)) begin
			stop_d = ptms_pkg::CNT_W'(lim_mag);
		end else begin
			stop_d = count_q;
		end
	end

	assign widx_p1  = ptms_pkg::CNT_W'(entry_index) + 1'b1;
	assign next_idx = feed_idx_q + 1'b1;

	// Table read: row 0 on the tolerance cycle, next row on the last axis
	assign tbl_rd_en   = (state_q == ptms_pkg::ST_TOL) |
	                     ((state_q == ptms_pkg::ST_FEED) & (axis_q == ptms_pkg::AX_Z));
	assign tbl_rd_addr = (state_q == ptms_pkg::ST_TOL) ? '0 : next_idx[ptms_pkg::ADDR_W-1:0];

	ptms_table u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	// Operand select for the shared distance unit
	always_comb begin
		du_valid   = (state_q == ptms_pkg::ST_TOL) | (state_q == ptms_pkg::ST_FEED);
		du_tag     = '0;
		du_tag.sel = tbl_rd_data.sel;
		du_tag.idx = feed_idx_q[ptms_pkg::ADDR_W-1:0];
		du_a       = qx_q;
		du_b       = tbl_rd_data.x;
		if (state_q == ptms_pkg::ST_TOL) begin
			// tolerance squared through the same multiplier
			du_a          = ptms_pkg::COORD_W'(tol_q);
			du_b          = '0;
			du_tag.is_tol = 1'b1;
		end else begin
			unique case (axis_q)
				ptms_pkg::AX_X: begin
					du_tag.first = 1'b1;
				end
				ptms_pkg::AX_Y: begin
					du_a = qy_q;
					du_b = tbl_rd_data.y;
				end
				ptms_pkg::AX_Z: begin
					du_a        = qz_q;
					du_b        = tbl_rd_data.z;
					du_tag.last = 1'b1;
				end
				default: begin
					du_a = qx_q;
				end
			endcase
		end
	end

	ptms_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (exact),
		.in_valid (du_valid),
		.op_a     (du_a),
		.op_b     (du_b),
		.tag_in   (du_tag),
		.res      (du_res)
	);

	// Accumulate squares and judge each entry on its last axis
	always_comb begin
		proc    = du_res.valid &
		          ((state_q == ptms_pkg::ST_FEED) | (state_q == ptms_pkg::ST_DRAIN));
		sum     = (du_res.tag.first ? '0 : acc_q) + ptms_pkg::ACC_W'(du_res.prod);
		ovf_any = du_res.ovf | (~du_res.tag.first & ovf_acc_q);
		cand    = proc & ~du_res.tag.is_tol & du_res.tag.last & du_res.tag.sel & ~ovf_any;
		exact   = cand & (sum == '0);
		near    = cand & (sum < ptms_pkg::ACC_W'(tol2_q));
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptms_pkg::ST_CLEAR: begin
				if (clr_idx_q == ptms_pkg::ADDR_W'(ptms_pkg::TABLE_DEPTH - 1)) begin
					state_d = ptms_pkg::ST_IDLE;
				end
			end
			ptms_pkg::ST_IDLE: begin
				if (qry_fire) begin
					state_d = ptms_pkg::ST_TOL;
				end
			end
			ptms_pkg::ST_TOL: begin
				state_d = (stop_q == '0) ? ptms_pkg::ST_DRAIN : ptms_pkg::ST_FEED;
			end
			ptms_pkg::ST_FEED: begin
				if (exact) begin
					state_d = ptms_pkg::ST_FINISH;
				end else if ((axis_q == ptms_pkg::AX_Z) && (next_idx == stop_q)) begin
					state_d = ptms_pkg::ST_DRAIN;
				end
			end
			ptms_pkg::ST_DRAIN: begin
				if (exact || !du_res.busy) begin
					state_d = ptms_pkg::ST_FINISH;
				end
			end
			ptms_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = ptms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptms_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptms_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			count_q     <= '0;
			tol_q       <= ptms_pkg::TOL_W'(1);
			feed_idx_q  <= '0;
			axis_q      <= ptms_pkg::AX_X;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ptms_pkg::ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cfg_valid) begin
				tol_q <= match_tolerance;
			end
			if (wr_fire && (widx_p1 > count_q)) begin
				count_q <= widx_p1;
			end
			// scan position
			if (state_q == ptms_pkg::ST_TOL) begin
				feed_idx_q <= '0;
				axis_q     <= ptms_pkg::AX_X;
			end else if (state_q == ptms_pkg::ST_FEED) begin
				unique case (axis_q)
					ptms_pkg::AX_X: axis_q <= ptms_pkg::AX_Y;
					ptms_pkg::AX_Y: axis_q <= ptms_pkg::AX_Z;
					ptms_pkg::AX_Z: begin
						axis_q     <= ptms_pkg::AX_X;
						feed_idx_q <= next_idx;
					end
					default: axis_q <= ptms_pkg::AX_X;
				endcase
			end
			// hit tracking, later hits replace earlier ones
			if (qry_fire) begin
				hit_q <= 1'b0;
			end else if (exact || near) begin
				hit_q <= 1'b1;
			end
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (qry_fire) begin
			qx_q   <= coord_x;
			qy_q   <= coord_y;
			qz_q   <= coord_z;
			stop_q <= stop_d;
		end
		if (proc && du_res.tag.is_tol) begin
			tol2_q <= du_res.prod;
		end
		if (proc && !du_res.tag.is_tol && !du_res.tag.last) begin
			acc_q     <= sum;
			ovf_acc_q <= ovf_any;
		end
		if (exact || near) begin
			hit_idx_q <= du_res.tag.idx;
		end
		if (out_load) begin
			found_q       <= hit_q;
			match_index_q <= hit_q ? ptms_pkg::IDX_OUT_W'(hit_idx_q) : '1;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign match_index = match_index_q;

endmodule

@@ rtl/core/ptms_checker.sv @@
// ptms_checker: port-level checks on the point tolerance match search, and its bind.
// Depends on ptms_pkg; attached to point_tolerance_match_search.
module ptms_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                opcode,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                found,
	input logic [ptms_pkg::IDX_OUT_W-1:0]      match_index
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_index))
		else $error("result changed while stalled");

	// Not found reports index -1
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (&match_index))
		else $error("miss without index -1");

	// Found reports a non-negative index
	a_hit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !match_index[ptms_pkg::IDX_OUT_W-1])
		else $error("hit with negative index");

	// A query transaction occupies the block
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == ptms_pkg::OP_QUERY) |=> !in_ready)
		else $error("input taken during a query");

	// A result appears only while a query is in work
	a_out_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a query");

endmodule

bind point_tolerance_match_search ptms_checker u_ptms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.found       (found),
	.match_index (match_index)
);

@@ verif/tb_point_tolerance_match_search.sv @@
`timescale 1ns / 100ps
// tb_point_tolerance_match_search: self-checking bench for the 3-D point table search.
// Depends on ptms_pkg and point_tolerance_match_search; carries its own table predictor.
module tb_point_tolerance_match_search;
	import ptms_pkg::*;

	typedef logic [ADDR_W-1:0]                slot_t;
	typedef logic signed [COORD_W-1:0]        coord_t;
	typedef logic signed [LIM_W-1:0]          limit_t;
	typedef logic signed [IDX_OUT_W-1:0]      slot_out_t;
	typedef logic [TOL_W-1:0]                 tol_t;

	typedef enum logic {ROW_ITEM, ROW_TOL} row_kind_t;

	typedef struct packed {
		logic      found;
		slot_out_t mi;
	} result_t;

	// One stimulus row: an input transaction or a tolerance change
	typedef struct {
		row_kind_t kind;
		logic      op;
		slot_t     idx;
		coord_t    x;
		coord_t    y;
		coord_t    z;
		logic      sel;
		limit_t    lim;
		tol_t      tol;
		bit        typed;
		result_t   res;
	} row_t;

	localparam coord_t C_MAX = 32'sh7FFF_FFFF;
	localparam coord_t C_MIN = 32'sh8000_0000;
	localparam coord_t Q_ONE = 32'sh0001_0000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 92;

	logic      clk             = 1'b0;
	logic      arst_n          = 1'b0;
	logic      in_valid        = 1'b0;
	logic      in_ready;
	logic      opcode          = OP_WRITE;
	slot_t     entry_index     = '0;
	coord_t    coord_x         = '0;
	coord_t    coord_y         = '0;
	coord_t    coord_z         = '0;
	logic      is_selected     = 1'b0;
	limit_t    scan_limit      = '0;
	logic      out_valid;
	logic      out_ready       = 1'b1;
	logic      found;
	slot_out_t match_index;
	logic      cfg_valid       = 1'b0;
	logic      cfg_ready;
	tol_t      match_tolerance = '0;

	// Shadow of the block state
	coord_t tbl_x [TABLE_DEPTH];
	coord_t tbl_y [TABLE_DEPTH];
	coord_t tbl_z [TABLE_DEPTH];
	bit     tbl_sel [TABLE_DEPTH];
	int     tbl_count = 0;
	tol_t   cur_tol   = 1;
	slot_t  written_slots [$];

	result_t pending_results [$];
	result_t want_res;
	row_t    dir_rows [$];
	int      error_count = 0;
	bit      calm        = 1'b0;

	point_tolerance_match_search u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.entry_index     (entry_index),
		.coord_x         (coord_x),
		.coord_y         (coord_y),
		.coord_z         (coord_z),
		.is_selected     (is_selected),
		.scan_limit      (scan_limit),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.match_index     (match_index),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.match_tolerance (match_tolerance)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("point_tolerance_match_search test failed");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		// keep the log short on a badly broken block
		if (error_count < 100)
			$display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// Squared axis difference; bit 64 marks a difference too large to be near
	function automatic logic [64:0] axis_square(coord_t a, coord_t b);
		longint     d;
		logic [63:0] m;
		d = longint'(a) - longint'(b);
		m = (d < 0) ? -d : d;
		if (m >= 64'h8000_0000)
			return {1'b1, 64'd0};
		return {1'b0, m * m};
	endfunction

	// Linear scan: first exact hit wins, else the last slot inside the tolerance
	function automatic result_t search_table(coord_t qx, coord_t qy, coord_t qz, limit_t lim);
		int          stop;
		logic [63:0] tol_sq;
		logic [63:0] acc;
		logic [64:0] sx, sy, sz;
		result_t     r;
		stop = tbl_count;
		if (lim >= 0 && int'(lim) < stop)
			stop = int'(lim);
		tol_sq = 64'(cur_tol) * 64'(cur_tol);
		r.found = 1'b0;
		r.mi = slot_out_t'(-1);
		for (int i = 0; i < stop; i++) begin
			if (!tbl_sel[i])
				continue;
			sx = axis_square(qx, tbl_x[i]);
			sy = axis_square(qy, tbl_y[i]);
			sz = axis_square(qz, tbl_z[i]);
			if (sx[64] || sy[64] || sz[64])
				continue;
			acc = sx[63:0] + sy[63:0] + sz[63:0];
			if (acc == 0) begin
				r.found = 1'b1;
				r.mi = slot_out_t'(i);
				break;
			end
			if (acc < tol_sq) begin
				r.found = 1'b1;
				r.mi = slot_out_t'(i);
			end
		end
		return r;
	endfunction

	function automatic void store_point(row_t r);
		tbl_x[r.idx] = r.x;
		tbl_y[r.idx] = r.y;
		tbl_z[r.idx] = r.z;
		tbl_sel[r.idx] = r.sel;
		if (int'(r.idx) + 1 > tbl_count)
			tbl_count = int'(r.idx) + 1;
		written_slots.push_back(r.idx);
	endfunction

	function automatic void add_item(logic op, int idx, coord_t x, coord_t y, coord_t z,
			logic sel, int lim, bit typed = 1'b0, logic fnd = 1'b0, int mi = -1);
		row_t r;
		r.kind = ROW_ITEM;
		r.op = op;
		r.idx = slot_t'(idx);
		r.x = x;
		r.y = y;
		r.z = z;
		r.sel = sel;
		r.lim = limit_t'(lim);
		r.tol = '0;
		r.typed = typed;
		r.res.found = fnd;
		r.res.mi = slot_out_t'(mi);
		dir_rows.push_back(r);
	endfunction

	function automatic void add_tol(tol_t v);
		row_t r;
		r.kind = ROW_TOL;
		r.op = OP_WRITE;
		r.idx = '0;
		r.x = '0;
		r.y = '0;
		r.z = '0;
		r.sel = 1'b0;
		r.lim = '0;
		r.tol = v;
		r.typed = 1'b0;
		r.res = '0;
		dir_rows.push_back(r);
	endfunction

	// Directed rows: extremes, overflowing differences, unselected slots, duplicates
	function automatic void build_directed();
		add_item(OP_QUERY, 0, 0, 0, 0, 0, -1, 1, 0, -1);
		add_item(OP_WRITE, 0, 0, 0, 0, 1, 0);
		add_item(OP_QUERY, 0, 0, 0, 0, 0, -1, 1, 1, 0);
		add_item(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, -1);
		add_item(OP_WRITE, 1023, C_MAX, C_MAX, C_MAX, 1, 0);
		add_item(OP_QUERY, 0, C_MAX, C_MAX, C_MAX, 0, -1, 1, 1, 1023);
		add_item(OP_QUERY, 0, C_MAX, C_MAX, C_MAX, 0, 1023, 1, 0, -1);
		add_item(OP_QUERY, 0, C_MAX, C_MAX, C_MAX, 0, 1024, 1, 1, 1023);
		add_item(OP_WRITE, 1, C_MIN, C_MIN, C_MIN, 1, -1);
		add_item(OP_QUERY, 1023, C_MAX, C_MAX, C_MAX, 1, -1, 1, 1, 1023);
		add_item(OP_QUERY, 0, C_MIN, C_MIN, C_MIN, 0, 2, 1, 1, 1);
		add_item(OP_WRITE, 2, 5, 5, 5, 0, 0);
		add_item(OP_QUERY, 0, 5, 5, 5, 0, 3, 1, 0, -1);
		add_item(OP_WRITE, 3, Q_ONE, 0, 0, 1, 0);
		add_item(OP_WRITE, 4, Q_ONE, 0, 0, 1, 0);
		add_item(OP_QUERY, 0, Q_ONE, 0, 0, 0, -1, 1, 1, 3);
		// one LSB away under the reset tolerance is not near
		add_item(OP_QUERY, 0, 1, 0, 0, 0, 8, 1, 0, -1);
		add_tol(31'h7FFF_FFFF);
		add_item(OP_QUERY, 0, 0, 0, 32'sh100, 0, 5);
		add_tol(31'h0);
		add_item(OP_QUERY, 0, 0, 0, 1, 0, -1, 1, 0, -1);
		add_item(OP_QUERY, 0, 0, 0, 0, 0, -1, 1, 1, 0);
		add_tol(31'h0001_0000);
		add_item(OP_QUERY, 0, 32'sh8000, 0, 0, 0, 5);
	endfunction

	// Coordinates: clusters with small offsets, raw random words, extremes
	function automatic coord_t pick_coord();
		coord_t base;
		case ($urandom_range(0, 3))
			0, 1: begin
				case ($urandom_range(0, 3))
					0: base = 0;
					1: base = Q_ONE;
					2: base = -Q_ONE;
					default: base = 32'sh0123_4567;
				endcase
				return base + $urandom_range(0, 24576) - 32'd12288;
			end
			2: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return C_MAX;
					1: return C_MIN;
					2: return 0;
					3: return -1;
					default: return Q_ONE;
				endcase
			end
		endcase
	endfunction

	// Offset inside the current tolerance on all three axes together when the tolerance is 2 or more
	function automatic coord_t jitter(coord_t c);
		logic [31:0] j;
		j = (cur_tol > 2) ? 32'(cur_tol >> 1) : 32'd1;
		return c + $urandom_range(0, 2 * j) - j;
	endfunction

	function automatic limit_t pick_limit();
		case ($urandom_range(0, 9))
			0: return -1;
			1: return 1024;
			2: return limit_t'($urandom_range(0, 1024));
			default: return limit_t'($urandom_range(0, 64));
		endcase
	endfunction

	function automatic row_t rand_item();
		row_t  r;
		slot_t s;
		int    k;
		r.kind = ROW_ITEM;
		r.tol = '0;
		r.typed = 1'b0;
		r.res = '0;
		r.sel = ($urandom_range(0, 4) != 0);
		r.lim = pick_limit();
		if ($urandom_range(0, 9) < 4) begin
			r.op = OP_WRITE;
			r.idx = ($urandom_range(0, 19) < 17) ? slot_t'($urandom_range(0, 47))
				: slot_t'($urandom_range(0, 1023));
			r.x = pick_coord();
			r.y = pick_coord();
			r.z = pick_coord();
		end else begin
			r.op = OP_QUERY;
			r.idx = slot_t'($urandom_range(0, 1023));
			s = written_slots[$urandom_range(0, written_slots.size() - 1)];
			k = $urandom_range(0, 19);
			if (k < 7) begin
				r.x = tbl_x[s];
				r.y = tbl_y[s];
				r.z = tbl_z[s];
			end else if (k < 12) begin
				r.x = jitter(tbl_x[s]);
				r.y = jitter(tbl_y[s]);
				r.z = jitter(tbl_z[s]);
			end else begin
				r.x = pick_coord();
				r.y = pick_coord();
				r.z = pick_coord();
			end
		end
		return r;
	endfunction

	function automatic tol_t phase_tol(int phase);
		case (phase)
			0: return 31'h7FFF_FFFF;
			1: return 31'h0;
			2: return 31'h0001_0000;
			3: return 31'h1;
			4: return tol_t'($urandom_range(1, 32'h4000));
			default: return tol_t'($urandom);
		endcase
	endfunction

	function automatic int pick_gap();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 19);
		if (k < 13)
			return 0;
		if (k < 19)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_stall();
		int k;
		if (calm)
			return 0;
		k = $urandom_range(0, 9);
		if (k < 5)
			return 0;
		if (k < 9)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// Drive one transaction, update the shadow on acceptance, then maybe idle
	task automatic send_item(input row_t r);
		int gap;
		opcode <= r.op;
		entry_index <= r.idx;
		coord_x <= r.x;
		coord_y <= r.y;
		coord_z <= r.z;
		is_selected <= r.sel;
		scan_limit <= r.lim;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (r.op == OP_WRITE)
			store_point(r);
		else
			pending_results.push_back(r.typed ? r.res : search_table(r.x, r.y, r.z, r.lim));
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every query has answered and the last write has landed
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_tolerance(input tol_t v);
		match_tolerance <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_tol = v;
	endtask

	// Result receiver with random back-pressure
	initial begin : receiver
		int hold;
		int run;
		do @(posedge clk); while (!arst_n);
		forever begin
			hold = pick_stall();
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	// Compare each result transaction with the oldest outstanding query
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no query outstanding, match_index",
					int'(match_index), 0);
			end else begin
				want_res = pending_results.pop_front();
				if (found !== want_res.found)
					flag_mismatch("found", int'(found), int'(want_res.found));
				if (match_index !== want_res.mi)
					flag_mismatch("match_index", int'(match_index), int'(want_res.mi));
			end
		end
	end

	initial begin : stimulus
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		build_directed();
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_TOL) begin
				settle();
				write_tolerance(dir_rows[k].tol);
			end else begin
				send_item(dir_rows[k]);
			end
		end
		// random phases, one tolerance each; the third one runs without idling
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			write_tolerance(phase_tol(phase));
			calm = (phase == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(rand_item());
		end
		in_valid <= 1'b0;
		n = 0;
		while (pending_results.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (32) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("queries left without a result", pending_results.size(), 0);
		if (error_count == 0)
			$display("point_tolerance_match_search test passed");
		else
			$display("point_tolerance_match_search test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ptms_pkg.sv
rtl/core/ptms_table.sv
rtl/core/ptms_dist_unit.sv
rtl/core/point_tolerance_match_search.sv
rtl/core/ptms_checker.sv
verif/tb_point_tolerance_match_search.sv
